[hw/rtl/iira_pkg.sv]
`default_nettype none

package iira_pkg;

	localparam int CAPACITY   = 64;
	localparam int WORD_W     = 32;
	localparam int LEN_W      = 7;
	localparam int OP_W       = 3;
	localparam int ST_W       = 2;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int TREE_FAN   = 8;
	localparam int TREE_GROUPS = (CAPACITY + TREE_FAN - 1) / TREE_FAN;

	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_RESIZE = 3'd4;
	localparam logic [OP_W-1:0] OP_PUSH   = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Broadcast from the control to every cell. All enables include the
	// handshake, and all but en also the success of the operation.
	typedef struct packed {
		logic                     en;
		logic                     rd_en;
		logic                     wr_en;
		logic                     ins_en;
		logic                     rem_en;
		logic                     rsz_en;
		logic                     push_en;
		logic [LEN_W-1:0]         pos;
		logic [LEN_W-1:0]         count;
		logic [LEN_W-1:0]         len;
		logic signed [WORD_W-1:0] data;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/iira_req_if.sv]
`default_nettype none

interface iira_req_if;
	logic                  valid;
	logic                  ready;
	logic [2:0]            operation;
	logic [6:0]            position;
	logic [6:0]            target_length;
	logic signed [31:0]    data_in;

	modport source (
		output valid, operation, position, target_length, data_in,
		input  ready
	);

	modport sink (
		input  valid, operation, position, target_length, data_in,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/iira_rsp_if.sv]
`default_nettype none

interface iira_rsp_if;
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    read_data;
	logic [6:0]            list_length;
	logic [1:0]            status;

	modport source (
		output valid, read_data, list_length, status,
		input  ready
	);

	modport sink (
		input  valid, read_data, list_length, status,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/iira_cell.sv]
`default_nettype none

module iira_cell (
	input  wire logic                             clk,
	input  wire logic [iira_pkg::IDX_W-1:0]       cell_index,
	input  wire iira_pkg::cell_ctl_t              ctl,
	input  wire logic signed [iira_pkg::WORD_W-1:0] left_word,
	input  wire logic signed [iira_pkg::WORD_W-1:0] right_word,
	output logic signed [iira_pkg::WORD_W-1:0]    word,
	output logic signed [iira_pkg::WORD_W-1:0]    rd_word
);
	import iira_pkg::*;

	logic [LEN_W-1:0]         idx;
	logic [LEN_W-1:0]         idx_p1;
	logic                     at_pos;
	logic signed [WORD_W-1:0] word_q;
	logic signed [WORD_W-1:0] word_nxt;
	logic signed [WORD_W-1:0] rd_q;

	assign idx    = LEN_W'(cell_index);
	assign idx_p1 = idx + LEN_W'(1);
	assign at_pos = (idx == ctl.pos);

	always_comb begin
		word_nxt = word_q;
		if (ctl.wr_en && at_pos) begin
			word_nxt = ctl.data;
		end else if (ctl.ins_en) begin
			if (at_pos) begin
				word_nxt = ctl.data;
			end else if (idx > ctl.pos && idx <= ctl.count) begin
				word_nxt = left_word;
			end
		end else if (ctl.rem_en) begin
			if (idx >= ctl.pos && idx_p1 < ctl.count) begin
				word_nxt = right_word;
			end
		end else if (ctl.rsz_en) begin
			// Only the newly exposed tail is zeroed.
			if (idx >= ctl.count && idx < ctl.len) begin
				word_nxt = '0;
			end
		end else if (ctl.push_en && idx == ctl.count) begin
			word_nxt = ctl.data;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
		if (ctl.en) begin
			rd_q <= (ctl.rd_en && at_pos) ? word_q : '0;
		end
	end

	assign word    = word_q;
	assign rd_word = rd_q;

endmodule

`default_nettype wire

[hw/rtl/iira_read_tree.sv]
`default_nettype none

module iira_read_tree (
	input  wire logic                               clk,
	input  wire logic signed [iira_pkg::WORD_W-1:0] rd_word [iira_pkg::CAPACITY],
	output logic signed [iira_pkg::WORD_W-1:0]      read_data
);
	import iira_pkg::*;

	logic [WORD_W-1:0] grp_or [TREE_GROUPS];
	logic [WORD_W-1:0] grp_s1 [TREE_GROUPS];
	logic [WORD_W-1:0] all_or;
	logic [WORD_W-1:0] out_s2;

	// At most one cell holds a nonzero word, so an OR collects it.
	always_comb begin
		for (int g = 0; g < TREE_GROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < TREE_FAN; k++) begin
				if (g * TREE_FAN + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | rd_word[g * TREE_FAN + k];
				end
			end
		end
	end

	always_comb begin
		all_or = '0;
		for (int g = 0; g < TREE_GROUPS; g++) begin
			all_or = all_or | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_or;
		out_s2 <= all_or;
	end

	assign read_data = signed'(out_s2);

endmodule

`default_nettype wire

[hw/rtl/indexed_insert_remove_array.sv]
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells,
// each cell taking a word from itself, from a neighbor, from the request or
// zero, so insert, remove, resize and push shift the whole list at once.
// Each request transaction yields one response transaction with the word
// read (zero unless a successful read), the new length and a status (ok,
// position out of range, capacity exceeded); a failed operation leaves the
// list unchanged. One request is handled at a time: a taken request passes
// through S_T1 and S_T2 to S_OUT, where the response is valid, and the next
// request is taken only after the response is taken and the control is back
// in S_IDLE. The response waits on the two-level registered OR tree that
// gathers the read word from the cells. The words have no reset; entries are
// defined as soon as the list covers them.
module indexed_insert_remove_array (
	input  wire logic   clk,
	input  wire logic   arst_n,
	iira_req_if.sink    req,
	iira_rsp_if.source  rsp
);
	import iira_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_T1   = 2'd1;
	localparam logic [1:0] S_T2   = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]       state_q;
	logic [LEN_W-1:0] count_q;
	logic [LEN_W-1:0] count_nxt;
	logic [LEN_W-1:0] len_q;
	logic [ST_W-1:0]  status_q;
	logic [ST_W-1:0]  status_nxt;
	logic             accept;
	logic             ok;
	logic             pos_lt_cnt;
	logic             full;
	cell_ctl_t        ctl;

	logic signed [WORD_W-1:0] cell_word [CAPACITY];
	logic signed [WORD_W-1:0] rd_word   [CAPACITY];
	logic signed [WORD_W-1:0] tree_data;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign pos_lt_cnt = (req.position < count_q);
	assign full       = (count_q == LEN_W'(CAPACITY));

	always_comb begin
		status_nxt = ST_OK;
		count_nxt  = count_q;
		case (req.operation)
			OP_READ, OP_WRITE: begin
				if (!pos_lt_cnt) status_nxt = ST_RANGE;
			end
			OP_INSERT: begin
				if (req.position > count_q) begin
					status_nxt = ST_RANGE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + LEN_W'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_lt_cnt) begin
					count_nxt = count_q - LEN_W'(1);
				end else begin
					status_nxt = ST_RANGE;
				end
			end
			OP_RESIZE: begin
				if (req.target_length > LEN_W'(CAPACITY)) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = req.target_length;
				end
			end
			OP_PUSH: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + LEN_W'(1);
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	assign ok = (status_nxt == ST_OK);

	always_comb begin
		ctl.en      = accept;
		ctl.rd_en   = accept && ok && (req.operation == OP_READ);
		ctl.wr_en   = accept && ok && (req.operation == OP_WRITE);
		ctl.ins_en  = accept && ok && (req.operation == OP_INSERT);
		ctl.rem_en  = accept && ok && (req.operation == OP_REMOVE);
		ctl.rsz_en  = accept && ok && (req.operation == OP_RESIZE);
		ctl.push_en = accept && ok && (req.operation == OP_PUSH);
		ctl.pos     = req.position;
		ctl.count   = count_q;
		ctl.len     = req.target_length;
		ctl.data    = req.data_in;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		iira_cell u_cell (
			.clk        (clk),
			.cell_index (IDX_W'(i)),
			.ctl        (ctl),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.rd_word    (rd_word[i])
		);
	end

	iira_read_tree u_tree (
		.clk       (clk),
		.rd_word   (rd_word),
		.read_data (tree_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_T1;
						count_q <= count_nxt;
					end
				end
				S_T1:  state_q <= S_T2;
				S_T2:  state_q <= S_OUT;
				S_OUT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q    <= count_nxt;
			status_q <= status_nxt;
		end
	end

	assign rsp.valid       = (state_q == S_OUT);
	assign rsp.read_data   = tree_data;
	assign rsp.list_length = len_q;
	assign rsp.status      = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LEN_W'(CAPACITY))
		else $error("list length exceeds capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while another is in flight");

	a_fail_keeps_list: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ok) |=> (count_q == $past(count_q)))
		else $error("failed operation changed the length");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.read_data == '0))
		else $error("error response carries nonzero data");
`endif

endmodule

`default_nettype wire
